>>> hw/rtl/rmcl_pkg.sv
package rmcl_pkg;

    localparam int COORD_W     = 12;
    localparam int INDEX_W     = 11;
    localparam int MOVE_W      = 3;
    localparam int MAX_CHAIN_D = 1024;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef enum logic [1:0] {
        AX_X,
        AX_Y,
        AX_Z
    } axis_t;

    // relative move codes
    typedef enum logic [MOVE_W-1:0] {
        MV_FRONT,
        MV_UP,
        MV_DOWN,
        MV_RIGHT,
        MV_LEFT
    } move_t;

    typedef struct packed {
        axis_t axis;
        logic  neg;
    } dir_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } vec_t;

    typedef struct packed {
        logic [INDEX_W-1:0] idx;
        vec_t               bb;
        vec_t               sc;
        logic               run_last;
        logic               chain_end;
    } result_t;

    localparam dir_t DIR_POS_X = '{axis: AX_X, neg: 1'b0};
    localparam dir_t DIR_NEG_X = '{axis: AX_X, neg: 1'b1};

    localparam vec_t BEAD0_POS = '{x: 12'sd1, y: 12'sd0, z: 12'sd0};
    localparam vec_t BEAD1_POS = '{x: 12'sd2, y: 12'sd0, z: 12'sd0};

    // new direction from the current one and a relative move; codes above
    // left act as left
    function automatic dir_t turn(dir_t d, logic [MOVE_W-1:0] mv);
        dir_t  r;
        axis_t first_ax;
        axis_t second_ax;
        first_ax  = (d.axis == AX_X) ? AX_Y : AX_X;
        second_ax = (d.axis == AX_X || d.axis == AX_Y) ? AX_Z : AX_Y;
        case (mv)
            MV_FRONT: r = d;
            MV_UP:    r = '{axis: first_ax,  neg: 1'b0};
            MV_DOWN:  r = '{axis: first_ax,  neg: 1'b1};
            MV_RIGHT: r = '{axis: second_ax, neg: 1'b0};
            default:  r = '{axis: second_ax, neg: 1'b1};
        endcase
        return r;
    endfunction

    // one lattice step, wraps at the coordinate width
    function automatic vec_t step_from(vec_t base, dir_t d);
        vec_t   r;
        coord_t delta;
        r     = base;
        delta = d.neg ? -12'sd1 : 12'sd1;
        case (d.axis)
            AX_X:    r.x = r.x + delta;
            AX_Y:    r.y = r.y + delta;
            default: r.z = r.z + delta;
        endcase
        return r;
    endfunction

endpackage

>>> hw/rtl/relative_move_chain_to_lattice_core.sv
// Each accepted request writes its results into the result queue, whose head drives the output.
// Throughput: one request per cycle while in_stall is low; the first request of a chain yields
// two results, while later requests yield one each.
// The 3-entry result queue stalls the input once it holds two or more results.
// Reset (rst_n, async, active low): empty queue, direction +x, backbone at (2,0,0),
// bead counter 0, no chain open.
module relative_move_chain_to_lattice_core
    import rmcl_pkg::*;
#(
    parameter int MAX_CHAIN = MAX_CHAIN_D
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // request channel
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [MOVE_W-1:0]        backbone_move,
    input  logic [MOVE_W-1:0]        side_move,
    input  logic                     final_element,
    // result channel
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [INDEX_W-1:0]       bead_index,
    output logic signed [COORD_W-1:0] bb_x,
    output logic signed [COORD_W-1:0] bb_y,
    output logic signed [COORD_W-1:0] bb_z,
    output logic signed [COORD_W-1:0] sc_x,
    output logic signed [COORD_W-1:0] sc_y,
    output logic signed [COORD_W-1:0] sc_z,
    output logic                     run_last,
    output logic                     chain_end
);

    // bead counter must hold MAX_CHAIN itself (saturation value)
    localparam int CNT_W     = $clog2(MAX_CHAIN + 1);
    localparam int START_CNT = (MAX_CHAIN < 2) ? MAX_CHAIN : 2;
    localparam int Q_DEPTH   = 3;
    localparam int QC_W      = 2;

    // chain state
    logic             started_reg, started_next;
    dir_t             dir_reg,     dir_next;
    vec_t             pos_reg,     pos_next;
    logic [CNT_W-1:0] bead_cnt_reg, bead_cnt_next;

    // result queue, head at entry 0 drives the output ports
    result_t          q_reg [Q_DEPTH];
    result_t          q_next [Q_DEPTH];
    logic [QC_W-1:0]  q_cnt_reg, q_cnt_next;

    logic             accept;
    logic             pop;
    logic             first_item;
    logic [QC_W-1:0]  base;
    logic [QC_W-1:0]  base_p1;
    logic [QC_W-1:0]  n_push;

    dir_t             bb_dir;
    dir_t             sc_dir;
    vec_t             new_pos;
    result_t          r0;
    result_t          r1;
    logic [CNT_W+INDEX_W-1:0] cnt_ext;

    // need room for two results before taking a request
    assign in_stall   = q_cnt_reg[1];
    assign out_valid  = (q_cnt_reg != '0);
    assign accept     = in_valid && !in_stall;
    assign pop        = out_valid && !out_stall;
    assign first_item = !started_reg;

    assign bead_index = q_reg[0].idx;
    assign bb_x       = q_reg[0].bb.x;
    assign bb_y       = q_reg[0].bb.y;
    assign bb_z       = q_reg[0].bb.z;
    assign sc_x       = q_reg[0].sc.x;
    assign sc_y       = q_reg[0].sc.y;
    assign sc_z       = q_reg[0].sc.z;
    assign run_last   = q_reg[0].run_last;
    assign chain_end  = q_reg[0].chain_end;

    assign cnt_ext = {{INDEX_W{1'b0}}, bead_cnt_reg};

    // Move decode: two chained turns and two unit steps, all narrow.
    always_comb
    begin
        bb_dir  = turn(dir_reg, backbone_move);
        new_pos = step_from(pos_reg, bb_dir);
        sc_dir  = turn(bb_dir, side_move);

        if (first_item)
        begin
            // bead 0: side chain hangs off the reversed start direction
            r0.idx       = '0;
            r0.bb        = BEAD0_POS;
            r0.sc        = step_from(BEAD0_POS, turn(DIR_NEG_X, backbone_move));
            r0.run_last  = 1'b0;
            r0.chain_end = 1'b0;
            r1.idx       = INDEX_W'(1);
            r1.bb        = BEAD1_POS;
            r1.sc        = step_from(BEAD1_POS, turn(DIR_POS_X, side_move));
            r1.run_last  = 1'b1;
            r1.chain_end = final_element;
            n_push       = QC_W'(2);
        end
        else
        begin
            r0.idx       = cnt_ext[INDEX_W-1:0];
            r0.bb        = new_pos;
            r0.sc        = step_from(new_pos, sc_dir);
            r0.run_last  = 1'b1;
            r0.chain_end = final_element;
            r1           = r0;
            n_push       = QC_W'(1);
        end
    end

    // Chain state update; the end flag returns everything to reset values.
    always_comb
    begin
        started_next  = started_reg;
        dir_next      = dir_reg;
        pos_next      = pos_reg;
        bead_cnt_next = bead_cnt_reg;
        if (accept)
        begin
            if (final_element)
            begin
                started_next  = 1'b0;
                dir_next      = DIR_POS_X;
                pos_next      = BEAD1_POS;
                bead_cnt_next = '0;
            end
            else if (first_item)
            begin
                started_next  = 1'b1;
                dir_next      = DIR_POS_X;
                pos_next      = BEAD1_POS;
                bead_cnt_next = CNT_W'(START_CNT);
            end
            else
            begin
                dir_next = bb_dir;
                pos_next = new_pos;
                if (bead_cnt_reg < CNT_W'(MAX_CHAIN))
                begin
                    bead_cnt_next = bead_cnt_reg + CNT_W'(1);
                end
            end
        end
    end

    // Queue: shift on pop, then write new results just past the survivors.
    always_comb
    begin
        base    = q_cnt_reg - QC_W'(pop);
        base_p1 = base + QC_W'(1);
        for (int i = 0; i < Q_DEPTH; i++)
        begin
            q_next[i] = q_reg[i];
        end
        if (pop)
        begin
            for (int i = 0; i < Q_DEPTH - 1; i++)
            begin
                q_next[i] = q_reg[i+1];
            end
        end
        if (accept)
        begin
            for (int i = 0; i < Q_DEPTH; i++)
            begin
                if (base == QC_W'(i))
                begin
                    q_next[i] = r0;
                end
                if (first_item && base_p1 == QC_W'(i))
                begin
                    q_next[i] = r1;
                end
            end
        end
        q_cnt_next = base + (accept ? n_push : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg  <= 1'b0;
            dir_reg      <= DIR_POS_X;
            pos_reg      <= BEAD1_POS;
            bead_cnt_reg <= '0;
            q_cnt_reg    <= '0;
        end
        else
        begin
            started_reg  <= started_next;
            dir_reg      <= dir_next;
            pos_reg      <= pos_next;
            bead_cnt_reg <= bead_cnt_next;
            q_cnt_reg    <= q_cnt_next;
        end
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < Q_DEPTH; i++)
        begin
            q_reg[i] <= q_next[i];
        end
    end

endmodule

>>> hw/rtl/rmcl_checker.sv
module rmcl_checker
    import rmcl_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_stall,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic [INDEX_W-1:0]        bead_index,
    input logic signed [COORD_W-1:0] bb_x,
    input logic signed [COORD_W-1:0] bb_y,
    input logic signed [COORD_W-1:0] bb_z,
    input logic                      run_last,
    input logic                      chain_end
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(bead_index) && $stable(bb_x)
            && $stable(bb_y) && $stable(bb_z) && $stable(run_last))
        else $error("result changed while stalled");

    // first result of a chain start is bead 0 at (1,0,0)
    a_bead0: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !run_last |-> bead_index == '0 && bb_x == 12'sd1
            && bb_y == 12'sd0 && bb_z == 12'sd0 && !chain_end)
        else $error("bad bead 0 result");

    // bead 0 is always followed directly by its partner result
    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !run_last |=> out_valid && run_last
            && bb_x == 12'sd2 && bb_y == 12'sd0 && bb_z == 12'sd0)
        else $error("bead 0 not followed by bead 1");

    // chain end only on the last result of a request
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && chain_end |-> run_last)
        else $error("chain end on non-final result");

    // a stalled request means results are waiting
    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |-> out_valid)
        else $error("request stalled with no pending result");

endmodule

bind relative_move_chain_to_lattice_core rmcl_checker u_rmcl_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .bead_index (bead_index),
    .bb_x       (bb_x),
    .bb_y       (bb_y),
    .bb_z       (bb_z),
    .run_last   (run_last),
    .chain_end  (chain_end)
);
